### sv/dcbvs_pkg.sv
// Shared types, register indexes, state and fault codes of the DC bus voltage supervisor.
`timescale 1ns / 1ps
`default_nettype none
package dcbvs_pkg;

    localparam int VOLT_W  = 10;
    localparam int COUNT_W = 16;
    localparam int DUTY_W  = 14;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;

    typedef logic [VOLT_W-1:0]    t_volt;
    typedef logic [COUNT_W-1:0]   t_count;
    typedef logic [DUTY_W-1:0]    t_duty;
    typedef logic [CFG_W-1:0]     t_cfg_data;
    typedef logic [CFG_IDX_W-1:0] t_cfg_index;
    typedef logic [2:0]           t_state_code;
    typedef logic [1:0]           t_fault;

    // Default parameter values
    localparam int SOFT_ON_DELAY_DEF       = 100;
    localparam int OVERVOLT_HYSTERESIS_DEF = 20;
    localparam int RIDE_FLAG_DELAY_DEF     = 10;
    localparam int UNDERVOLT_MARGIN_DEF    = 2;

    localparam t_duty DUTY_MAX = t_duty'(10000);

    // Register indexes
    localparam t_cfg_index REG_POWER_UP   = 3'd0;
    localparam t_cfg_index REG_OVER_VOLT  = 3'd1;
    localparam t_cfg_index REG_BRAKE_ON   = 3'd2;
    localparam t_cfg_index REG_BRAKE_OFF  = 3'd3;
    localparam t_cfg_index REG_UNDER_VOLT = 3'd4;
    localparam t_cfg_index REG_SOFT_OFF   = 3'd5;
    localparam t_cfg_index REG_RIDE_TIME  = 3'd6;
    localparam t_cfg_index REG_BRAKE_DUTY = 3'd7;

    // Reported state codes
    localparam t_state_code CODE_INIT   = 3'd0;
    localparam t_state_code CODE_NORMAL = 3'd1;
    localparam t_state_code CODE_UNDER  = 3'd2;
    localparam t_state_code CODE_BRAKE  = 3'd3;
    localparam t_state_code CODE_OVER   = 3'd4;

    // Fault report codes
    localparam t_fault FAULT_NONE  = 2'd0;
    localparam t_fault FAULT_UNDER = 2'd1;
    localparam t_fault FAULT_OVER  = 2'd2;

    typedef enum logic [4:0] {
        ST_INIT   = 5'b00001,
        ST_NORMAL = 5'b00010,
        ST_UNDER  = 5'b00100,
        ST_BRAKE  = 5'b01000,
        ST_OVER   = 5'b10000
    } t_state;

endpackage
`default_nettype wire

### sv/dcbvs_in_if.sv
// Input channel of the DC bus voltage supervisor: one voltage sample and two flags per item.
`timescale 1ns / 1ps
`default_nettype none
interface dcbvs_in_if;
    logic                 valid;
    logic                 ready;
    dcbvs_pkg::t_volt     bus_voltage;
    logic                 power_off;
    logic                 overload_reset_pending;

    modport source (output valid, output bus_voltage, output power_off,
                    output overload_reset_pending, input ready);
    modport sink   (input valid, input bus_voltage, input power_off,
                    input overload_reset_pending, output ready);
endinterface
`default_nettype wire

### sv/dcbvs_out_if.sv
// Result channel of the DC bus voltage supervisor: state, relay, duty, ride-through and fault.
`timescale 1ns / 1ps
`default_nettype none
interface dcbvs_out_if;
    logic                   valid;
    logic                   ready;
    dcbvs_pkg::t_state_code supervisor_state;
    logic                   relay_closed;
    dcbvs_pkg::t_duty       chopper_duty;
    logic                   ride_through_active;
    dcbvs_pkg::t_fault      fault_report;

    modport source (output valid, output supervisor_state, output relay_closed,
                    output chopper_duty, output ride_through_active,
                    output fault_report, input ready);
    modport sink   (input valid, input supervisor_state, input relay_closed,
                    input chopper_duty, input ride_through_active,
                    input fault_report, output ready);
endinterface
`default_nettype wire

### sv/dc_bus_voltage_supervisor_core.sv
// DC bus voltage supervisor: input register, state update logic and result register.
//
// Usage: each control tick, send one item on i_in (bus_voltage, power_off,
// overload_reset_pending). For every item exactly one result appears on o_out
// carrying the supervisor state after the item, relay drive, chopper duty,
// ride-through flag and any fault reported on that tick.
// Thresholds, ride-through time and brake duty sit in eight registers written
// through i_cfg_we / i_cfg_index / i_cfg_data; write them only while idle.
// An accepted item passes through the input register, then the result register.
// Throughput: one item per cycle while o_out does not stall, set by the single
// pass of compare-and-update logic between the two registers.
// When o_out stalls, the result register holds and the input register fills;
// i_in.ready drops only once both are occupied, and rises again as soon as
// the receiver takes the waiting result.
// Reset (synchronous, active low) empties both registers, loads register
// defaults and puts the machine in init with the relay open and duty zero.
`timescale 1ns / 1ps
`default_nettype none
module dc_bus_voltage_supervisor_core #(
    parameter int SOFT_ON_DELAY       = dcbvs_pkg::SOFT_ON_DELAY_DEF,
    parameter int OVERVOLT_HYSTERESIS = dcbvs_pkg::OVERVOLT_HYSTERESIS_DEF,
    parameter int RIDE_FLAG_DELAY     = dcbvs_pkg::RIDE_FLAG_DELAY_DEF,
    parameter int UNDERVOLT_MARGIN    = dcbvs_pkg::UNDERVOLT_MARGIN_DEF
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    dcbvs_in_if.sink                 i_in,
    dcbvs_out_if.source              o_out,
    input  wire                      i_cfg_we,
    input  dcbvs_pkg::t_cfg_index    i_cfg_index,
    input  dcbvs_pkg::t_cfg_data     i_cfg_data
);
    import dcbvs_pkg::*;

    localparam t_count SOFT_DELAY_C = t_count'(SOFT_ON_DELAY);
    localparam t_count RIDE_DELAY_C = t_count'(RIDE_FLAG_DELAY);
    localparam logic [VOLT_W:0] HYST_C   = (VOLT_W+1)'(OVERVOLT_HYSTERESIS);
    localparam logic [VOLT_W:0] MARGIN_C = (VOLT_W+1)'(UNDERVOLT_MARGIN);

    // Configuration registers
    t_volt  r_power_up, r_over_volt, r_brake_on, r_brake_off, r_under_volt, r_soft_off;
    t_count r_ride_time;
    t_duty  r_brake_duty;

    // Input register
    logic   r_in_valid;
    t_volt  r_in_volt;
    logic   r_in_pwr_off;
    logic   r_in_ovl;

    // Machine state
    t_state r_mode, n_mode;
    t_count r_ss_cnt, n_ss_cnt;
    t_count r_uv_cnt, n_uv_cnt;
    logic   r_ride, n_ride;
    logic   r_relay, n_relay;
    t_duty  r_duty, n_duty;
    t_fault n_fault;

    // Result register
    logic        r_out_valid;
    t_state_code r_out_state;
    logic        r_out_relay;
    t_duty       r_out_duty;
    logic        r_out_ride;
    t_fault      r_out_fault;

    logic        w_out_free;
    logic        w_adv;
    t_duty       w_bduty;
    t_count      w_uv_inc;
    t_count      w_ss_inc;
    t_state_code w_code;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_adv      = r_in_valid && w_out_free;
    assign i_in.ready = !r_in_valid || w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power_up   <= t_volt'(200);
            r_over_volt  <= t_volt'(420);
            r_brake_on   <= t_volt'(380);
            r_brake_off  <= t_volt'(370);
            r_under_volt <= t_volt'(180);
            r_soft_off   <= t_volt'(150);
            r_ride_time  <= t_count'(300);
            r_brake_duty <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_POWER_UP:   r_power_up   <= i_cfg_data[VOLT_W-1:0];
                REG_OVER_VOLT:  r_over_volt  <= i_cfg_data[VOLT_W-1:0];
                REG_BRAKE_ON:   r_brake_on   <= i_cfg_data[VOLT_W-1:0];
                REG_BRAKE_OFF:  r_brake_off  <= i_cfg_data[VOLT_W-1:0];
                REG_UNDER_VOLT: r_under_volt <= i_cfg_data[VOLT_W-1:0];
                REG_SOFT_OFF:   r_soft_off   <= i_cfg_data[VOLT_W-1:0];
                REG_RIDE_TIME:  r_ride_time  <= i_cfg_data[COUNT_W-1:0];
                REG_BRAKE_DUTY: r_brake_duty <= i_cfg_data[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_volt    <= i_in.bus_voltage;
            r_in_pwr_off <= i_in.power_off;
            r_in_ovl     <= i_in.overload_reset_pending;
        end
    end

    assign w_bduty  = (r_brake_duty > DUTY_MAX) ? DUTY_MAX : r_brake_duty;
    assign w_uv_inc = (r_uv_cnt != {COUNT_W{1'b1}}) ? r_uv_cnt + t_count'(1) : r_uv_cnt;
    assign w_ss_inc = r_ss_cnt + t_count'(1);

    always_comb begin
        n_mode   = r_mode;
        n_ss_cnt = r_ss_cnt;
        n_uv_cnt = r_uv_cnt;
        n_ride   = r_ride;
        n_relay  = r_relay;
        n_duty   = r_duty;
        n_fault  = FAULT_NONE;
        unique case (r_mode)
            ST_NORMAL: begin
                n_relay  = 1'b1;
                n_uv_cnt = '0;
                if (r_in_volt > r_brake_on) begin
                    n_mode = ST_BRAKE;
                    n_duty = '0;
                end else if (r_in_volt < r_under_volt) begin
                    n_mode = ST_UNDER;
                end
            end
            ST_UNDER: begin
                n_uv_cnt = w_uv_inc;
                if (r_in_volt < r_soft_off) begin
                    n_mode   = ST_INIT;
                    n_fault  = r_in_pwr_off ? FAULT_NONE : FAULT_UNDER;
                    n_relay  = 1'b0;
                    n_uv_cnt = '0;
                    n_ride   = 1'b0;
                end else if ({1'b0, r_in_volt} > {1'b0, r_under_volt} + MARGIN_C) begin
                    n_mode   = ST_NORMAL;
                    n_uv_cnt = '0;
                    n_ride   = 1'b0;
                end else if (w_uv_inc > r_ride_time) begin
                    // ride-through expired: report unless power_off, and hold the count at the limit
                    n_fault  = r_in_pwr_off ? FAULT_NONE : FAULT_UNDER;
                    n_uv_cnt = r_ride_time;
                    n_ride   = 1'b0;
                end else if (w_uv_inc > RIDE_DELAY_C) begin
                    n_ride = 1'b1;
                end
            end
            ST_BRAKE: begin
                if (r_in_volt > r_over_volt) begin
                    n_mode  = ST_OVER;
                    n_fault = FAULT_OVER;
                end else if (r_in_volt < r_brake_off) begin
                    n_mode = ST_NORMAL;
                    n_duty = '0;
                end else begin
                    n_duty = r_in_ovl ? '0 : w_bduty;
                end
            end
            ST_OVER: begin
                // leave only once the bus has dropped below the level minus hysteresis
                if ({1'b0, r_in_volt} + HYST_C < {1'b0, r_over_volt}) begin
                    n_mode = ST_BRAKE;
                end
            end
            default: begin
                n_mode = ST_INIT;
                if (r_in_volt > r_power_up) begin
                    n_relay  = 1'b1;
                    n_ss_cnt = w_ss_inc;
                    if (w_ss_inc > SOFT_DELAY_C) begin
                        n_ss_cnt = '0;
                        n_mode   = ST_NORMAL;
                    end
                end else begin
                    n_ss_cnt = '0;
                end
            end
        endcase
    end

    always_comb begin
        unique case (n_mode)
            ST_NORMAL: w_code = CODE_NORMAL;
            ST_UNDER:  w_code = CODE_UNDER;
            ST_BRAKE:  w_code = CODE_BRAKE;
            ST_OVER:   w_code = CODE_OVER;
            default:   w_code = CODE_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= ST_INIT;
            r_ss_cnt <= '0;
            r_uv_cnt <= '0;
            r_ride   <= 1'b0;
            r_relay  <= 1'b0;
            r_duty   <= '0;
        end else if (w_adv) begin
            r_mode   <= n_mode;
            r_ss_cnt <= n_ss_cnt;
            r_uv_cnt <= n_uv_cnt;
            r_ride   <= n_ride;
            r_relay  <= n_relay;
            r_duty   <= n_duty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_state <= w_code;
            r_out_relay <= n_relay;
            r_out_duty  <= n_duty;
            r_out_ride  <= n_ride;
            r_out_fault <= n_fault;
        end
    end

    assign o_out.valid               = r_out_valid;
    assign o_out.supervisor_state    = r_out_state;
    assign o_out.relay_closed        = r_out_relay;
    assign o_out.chopper_duty        = r_out_duty;
    assign o_out.ride_through_active = r_out_ride;
    assign o_out.fault_report        = r_out_fault;

    // An open relay is only ever reported from init
    a_relay_open_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.relay_closed) |-> (o_out.supervisor_state == CODE_INIT))
        else $error("relay open outside init");

    // Overvolt fault comes together with the overvolt state
    a_over_fault_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.fault_report == FAULT_OVER)
            |-> (o_out.supervisor_state == CODE_OVER))
        else $error("overvolt fault outside overvolt state");

    // Ride-through flag lives only in undervolt
    a_ride_in_under: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ride_through_active)
            |-> (o_out.supervisor_state == CODE_UNDER))
        else $error("ride-through active outside undervolt");

    // Duty never exceeds the clamp
    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_duty <= DUTY_MAX))
        else $error("chopper duty out of range");

    // Machine state moves only when an item advances
    a_mode_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_adv) |=> $stable(r_mode))
        else $error("state changed without an item");

endmodule
`default_nettype wire

### sim/tb_dc_bus_voltage_supervisor_core.sv
// Self-checking testbench of the DC bus voltage supervisor: predicted against observed results.
`timescale 1ns / 1ps
module tb_dc_bus_voltage_supervisor_core;
    import dcbvs_pkg::*;

    localparam int NUM_LEVELS  = 8;
    localparam int VOLT_MAX    = (1 << VOLT_W) - 1;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        t_state_code state;
        logic        relay;
        t_duty       duty;
        logic        ride;
        t_fault      fault;
    } t_status;

    class supervisor_scoreboard;
        int unsigned level_reg[NUM_LEVELS];
        t_state_code mode;
        int unsigned soft_start_ticks;
        int unsigned undervolt_ticks;
        bit          ride_flag;
        bit          relay;
        t_duty       duty_now;
        t_status     status_due[$];
        int          mismatches;

        function new();
            level_reg[REG_POWER_UP]   = 200;
            level_reg[REG_OVER_VOLT]  = 420;
            level_reg[REG_BRAKE_ON]   = 380;
            level_reg[REG_BRAKE_OFF]  = 370;
            level_reg[REG_UNDER_VOLT] = 180;
            level_reg[REG_SOFT_OFF]   = 150;
            level_reg[REG_RIDE_TIME]  = 300;
            level_reg[REG_BRAKE_DUTY] = 0;
            mode             = CODE_INIT;
            soft_start_ticks = 0;
            undervolt_ticks  = 0;
            ride_flag        = 1'b0;
            relay            = 1'b0;
            duty_now         = '0;
            mismatches       = 0;
        endfunction

        function void write_reg(t_cfg_index idx, t_cfg_data data);
            case (idx)
                REG_RIDE_TIME:  level_reg[idx] = data;
                REG_BRAKE_DUTY: level_reg[idx] = data[DUTY_W-1:0];
                default:        level_reg[idx] = data[VOLT_W-1:0];
            endcase
        endfunction

        function t_status advance_supervisor(t_volt v, bit pwr_off, bit ovl);
            int          vi, pu, ov, bon, boff, uv, soff;
            int unsigned bduty;
            t_status     st;
            vi    = int'(v);
            pu    = int'(level_reg[REG_POWER_UP]);
            ov    = int'(level_reg[REG_OVER_VOLT]);
            bon   = int'(level_reg[REG_BRAKE_ON]);
            boff  = int'(level_reg[REG_BRAKE_OFF]);
            uv    = int'(level_reg[REG_UNDER_VOLT]);
            soff  = int'(level_reg[REG_SOFT_OFF]);
            bduty = (level_reg[REG_BRAKE_DUTY] > DUTY_MAX) ? DUTY_MAX : level_reg[REG_BRAKE_DUTY];
            st.fault = FAULT_NONE;
            case (mode)
                CODE_NORMAL: begin
                    relay = 1'b1;
                    if (vi > bon) begin
                        mode     = CODE_BRAKE;
                        duty_now = '0;
                    end else if (vi < uv) begin
                        mode = CODE_UNDER;
                    end
                    undervolt_ticks = 0;
                end
                CODE_UNDER: begin
                    if (undervolt_ticks < 32'hFFFF)
                        undervolt_ticks++;
                    if (vi < soff) begin
                        mode = CODE_INIT;
                        if (!pwr_off)
                            st.fault = FAULT_UNDER;
                        relay           = 1'b0;
                        undervolt_ticks = 0;
                        ride_flag       = 1'b0;
                    end else if (vi > uv + UNDERVOLT_MARGIN_DEF) begin
                        mode            = CODE_NORMAL;
                        undervolt_ticks = 0;
                        ride_flag       = 1'b0;
                    end else if (undervolt_ticks > level_reg[REG_RIDE_TIME]) begin
                        // report and pin the count so the fault repeats each tick
                        if (!pwr_off)
                            st.fault = FAULT_UNDER;
                        undervolt_ticks = level_reg[REG_RIDE_TIME];
                        ride_flag       = 1'b0;
                    end else if (undervolt_ticks > RIDE_FLAG_DELAY_DEF) begin
                        ride_flag = 1'b1;
                    end
                end
                CODE_BRAKE: begin
                    if (vi > ov) begin
                        mode     = CODE_OVER;
                        st.fault = FAULT_OVER;
                    end else if (vi < boff) begin
                        mode     = CODE_NORMAL;
                        duty_now = '0;
                    end else begin
                        duty_now = ovl ? t_duty'(0) : t_duty'(bduty);
                    end
                end
                CODE_OVER: begin
                    // signed compare: a level below the hysteresis never lets go
                    if (vi < ov - OVERVOLT_HYSTERESIS_DEF)
                        mode = CODE_BRAKE;
                end
                default: begin
                    mode = CODE_INIT;
                    if (vi > pu) begin
                        relay = 1'b1;
                        soft_start_ticks++;
                        if (soft_start_ticks > SOFT_ON_DELAY_DEF) begin
                            soft_start_ticks = 0;
                            mode             = CODE_NORMAL;
                        end
                    end else begin
                        soft_start_ticks = 0;
                    end
                end
            endcase
            st.state = mode;
            st.relay = relay;
            st.duty  = duty_now;
            st.ride  = ride_flag;
            return st;
        endfunction

        function void take_sample(t_volt v, bit pwr_off, bit ovl);
            status_due.push_back(advance_supervisor(v, pwr_off, ovl));
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_status(t_status got);
            t_status want;
            string   diffs;
            if (status_due.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected, state %0d", got.state));
                return;
            end
            want  = status_due.pop_front();
            diffs = "";
            if (got.state !== want.state)
                diffs = {diffs, $sformatf(" state %0d/%0d", got.state, want.state)};
            if (got.relay !== want.relay)
                diffs = {diffs, $sformatf(" relay %0d/%0d", got.relay, want.relay)};
            if (got.duty !== want.duty)
                diffs = {diffs, $sformatf(" duty %0d/%0d", got.duty, want.duty)};
            if (got.ride !== want.ride)
                diffs = {diffs, $sformatf(" ride %0d/%0d", got.ride, want.ride)};
            if (got.fault !== want.fault)
                diffs = {diffs, $sformatf(" fault %0d/%0d", got.fault, want.fault)};
            if (diffs != "")
                report_mismatch({"field got/want:", diffs});
        endtask
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    t_cfg_index i_cfg_index;
    t_cfg_data  i_cfg_data;

    dcbvs_in_if  in_ch ();
    dcbvs_out_if out_ch ();

    dc_bus_voltage_supervisor_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    supervisor_scoreboard sb;
    t_cfg_data            level_set[NUM_LEVELS];
    t_status              seen_status;
    bit                   idle_on = 1'b1;
    bit                   hold_off_req = 1'b0;
    int                   cycle_count = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            seen_status.state = out_ch.supervisor_state;
            seen_status.relay = out_ch.relay_closed;
            seen_status.duty  = out_ch.chopper_duty;
            seen_status.ride  = out_ch.ride_through_active;
            seen_status.fault = out_ch.fault_report;
            sb.check_status(seen_status);
        end
    end

    // Result receiver: random stalls, plus one long hold-off on request
    initial begin
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                out_ch.ready <= 1'b0;
                repeat (80) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    function automatic int clamp_volt(int x);
        return (x < 0) ? 0 : ((x > VOLT_MAX) ? VOLT_MAX : x);
    endfunction

    // Random filler above the register width; the block must drop it
    function automatic t_cfg_data with_junk(int value, int width);
        return t_cfg_data'(value) | (t_cfg_data'($urandom) << width);
    endfunction

    task automatic send_item(t_volt v, bit pwr_off, bit ovl);
        in_ch.valid                  <= 1'b1;
        in_ch.bus_voltage            <= v;
        in_ch.power_off              <= pwr_off;
        in_ch.overload_reset_pending <= ovl;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1)
            @(posedge i_clk);
        sb.take_sample(v, pwr_off, ovl);
    endtask

    task automatic idle_input(int cycles);
        in_ch.valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (sb.status_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_levels();
        wait_drained();
        for (int i = 0; i < NUM_LEVELS; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= t_cfg_index'(i);
            i_cfg_data  <= level_set[i];
            @(posedge i_clk);
            sb.write_reg(t_cfg_index'(i), level_set[i]);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_level_set();
        int soff, uv, pu, boff, bon, ov;
        soff = $urandom_range(50, 200);
        uv   = soff + $urandom_range(5, 60);
        pu   = uv + $urandom_range(0, 60);
        boff = pu + $urandom_range(20, 200);
        bon  = boff + $urandom_range(0, 40);
        ov   = bon + $urandom_range(0, 80);
        level_set[REG_POWER_UP]   = with_junk(pu, VOLT_W);
        level_set[REG_OVER_VOLT]  = with_junk(ov, VOLT_W);
        level_set[REG_BRAKE_ON]   = with_junk(bon, VOLT_W);
        level_set[REG_BRAKE_OFF]  = with_junk(boff, VOLT_W);
        level_set[REG_UNDER_VOLT] = with_junk(uv, VOLT_W);
        level_set[REG_SOFT_OFF]   = with_junk(soff, VOLT_W);
        level_set[REG_RIDE_TIME]  = t_cfg_data'($urandom_range(0, 60));
        level_set[REG_BRAKE_DUTY] = with_junk($urandom_range(0, (1 << DUTY_W) - 1), DUTY_W);
    endtask

    // Voltage walk: hold a level picked near one threshold band, with noise
    task automatic run_walk(int n_items, int drain_at);
        int target, hold, lo, hi, v;
        int pu, ov, bon, boff, uv, soff;
        bit init_plan;
        target    = 0;
        hold      = 0;
        init_plan = 1'b0;
        for (int k = 0; k < n_items; k++) begin
            if (k == drain_at)
                wait_drained();
            if (hold == 0) begin
                pu   = int'(sb.level_reg[REG_POWER_UP]);
                ov   = int'(sb.level_reg[REG_OVER_VOLT]);
                bon  = int'(sb.level_reg[REG_BRAKE_ON]);
                boff = int'(sb.level_reg[REG_BRAKE_OFF]);
                uv   = int'(sb.level_reg[REG_UNDER_VOLT]);
                soff = int'(sb.level_reg[REG_SOFT_OFF]);
                lo   = 0;
                hi   = VOLT_MAX;
                init_plan = 1'b0;
                if (sb.mode == CODE_INIT && $urandom_range(0, 4) != 0) begin
                    // hold above power-up long enough to finish soft start
                    init_plan = 1'b1;
                    lo   = pu + 1;
                    hold = $urandom_range(105, 130);
                end else begin
                    hold = $urandom_range(1, 40);
                    case ($urandom_range(0, 5))
                        0: begin
                            lo = ov - 25;
                            hi = ov + 5;
                        end
                        1: begin
                            lo = boff - 3;
                            hi = bon + 3;
                        end
                        2: begin
                            lo = uv;
                            hi = boff;
                        end
                        3: begin
                            lo   = soff - 2;
                            hi   = uv + 4;
                            hold = $urandom_range(5, 80);
                        end
                        4: begin
                            hi = soff;
                        end
                        default: ;
                    endcase
                end
                lo     = clamp_volt(lo);
                hi     = clamp_volt(hi);
                target = $urandom_range(hi, lo);
            end
            hold--;
            if (init_plan)
                v = target + $urandom_range(0, 3);
            else if ($urandom_range(0, 11) == 0)
                v = $urandom_range(0, VOLT_MAX);
            else
                v = target + int'($urandom_range(0, 6)) - 3;
            if (idle_on && !hold_off_req && $urandom_range(0, 4) == 0)
                idle_input($urandom_range(1, 19));
            send_item(t_volt'(clamp_volt(v)), $urandom_range(0, 3) == 0,
                      $urandom_range(0, 3) == 0);
        end
    endtask

    initial begin
        sb = new();
        i_rst_n                      <= 1'b0;
        i_cfg_we                     <= 1'b0;
        i_cfg_index                  <= REG_POWER_UP;
        i_cfg_data                   <= '0;
        in_ch.valid                  <= 1'b0;
        in_ch.bus_voltage            <= '0;
        in_ch.power_off              <= 1'b0;
        in_ch.overload_reset_pending <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Field extremes and the power-up boundary under reset levels
        send_item(t_volt'(0), 1'b0, 1'b0);
        send_item(t_volt'(VOLT_MAX), 1'b1, 1'b1);
        send_item(t_volt'(200), 1'b0, 1'b1);
        send_item(t_volt'(201), 1'b1, 1'b0);
        send_item(t_volt'(0), 1'b1, 1'b1);
        send_item(t_volt'(VOLT_MAX), 1'b0, 1'b0);
        send_item(t_volt'(201), 1'b0, 1'b0);
        send_item(t_volt'(VOLT_MAX), 1'b1, 1'b0);
        run_walk(130, -1);

        level_set[REG_POWER_UP]   = t_cfg_data'(200);
        level_set[REG_OVER_VOLT]  = t_cfg_data'(420);
        level_set[REG_BRAKE_ON]   = t_cfg_data'(380);
        level_set[REG_BRAKE_OFF]  = t_cfg_data'(370);
        level_set[REG_UNDER_VOLT] = t_cfg_data'(180);
        level_set[REG_SOFT_OFF]   = t_cfg_data'(150);
        level_set[REG_RIDE_TIME]  = t_cfg_data'(20);
        level_set[REG_BRAKE_DUTY] = t_cfg_data'(5000);
        load_levels();
        run_walk(170, 85);

        // Low extremes: overvolt below hysteresis, maximum ride-through time, duty clamp
        level_set[REG_POWER_UP]   = t_cfg_data'(0);
        level_set[REG_OVER_VOLT]  = t_cfg_data'(10);
        level_set[REG_BRAKE_ON]   = t_cfg_data'(700);
        level_set[REG_BRAKE_OFF]  = t_cfg_data'(600);
        level_set[REG_UNDER_VOLT] = t_cfg_data'(1);
        level_set[REG_SOFT_OFF]   = t_cfg_data'(0);
        level_set[REG_RIDE_TIME]  = t_cfg_data'(16'hFFFF);
        level_set[REG_BRAKE_DUTY] = t_cfg_data'((1 << DUTY_W) - 1);
        load_levels();
        run_walk(100, -1);

        // High extremes: zero ride-through, full duty
        level_set[REG_POWER_UP]   = t_cfg_data'(1000);
        level_set[REG_OVER_VOLT]  = t_cfg_data'(VOLT_MAX);
        level_set[REG_BRAKE_ON]   = t_cfg_data'(1010);
        level_set[REG_BRAKE_OFF]  = t_cfg_data'(990);
        level_set[REG_UNDER_VOLT] = t_cfg_data'(950);
        level_set[REG_SOFT_OFF]   = t_cfg_data'(900);
        level_set[REG_RIDE_TIME]  = t_cfg_data'(0);
        level_set[REG_BRAKE_DUTY] = t_cfg_data'(DUTY_MAX);
        load_levels();
        run_walk(120, -1);

        // Stall the receiver for a long stretch while items keep coming
        random_level_set();
        load_levels();
        hold_off_req = 1'b1;
        run_walk(160, -1);

        random_level_set();
        load_levels();
        idle_on = 1'b0;
        run_walk(150, -1);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

### sim.f
sv/dcbvs_pkg.sv
sv/dcbvs_in_if.sv
sv/dcbvs_out_if.sv
sv/dc_bus_voltage_supervisor_core.sv
sim/tb_dc_bus_voltage_supervisor_core.sv
